@@ hdl/sgrm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the solid grid rectangle merger: payload structs, config codes,
// controller/datapath command and status structs. No dependencies.
package sgrm_pkg;

    // Fixed field widths
    localparam int ROW_MASK_W = 64;
    localparam int ROW_IDX_W  = 6;
    localparam int RECT_W     = 14;
    localparam int MAP_DIM_W  = 7;
    localparam int TILE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Input command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd3;

    typedef struct packed {
        logic                  command;
        logic [ROW_IDX_W-1:0]  row_index;
        logic [ROW_MASK_W-1:0] row_mask;
    } t_in_item;

    typedef struct packed {
        logic              done_res;
        logic [RECT_W-1:0] rect_x;
        logic [RECT_W-1:0] rect_y;
        logic [RECT_W-1:0] rect_w;
        logic [RECT_W-1:0] rect_h;
    } t_out_item;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [MAP_DIM_W-1:0] map_width;
        logic [MAP_DIM_W-1:0] map_height;
        logic [TILE_W-1:0]    tile_width;
        logic [TILE_W-1:0]    tile_height;
        logic                 scan_restart;
    } t_cfg;

    // Controller -> datapath
    typedef struct packed {
        logic load;   // load transaction accepted
        logic start;  // fetch transaction accepted
        logic scan;   // scanning one row per cycle
        logic run;    // forming the horizontal run
        logic ext;    // extending downward one row per cycle
        logic res;    // forming the result
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic degen;     // zero map or tile size
        logic row_ge_h;  // scan ran past the last row
        logic row_hit;   // current row has a free cell (at or after the scan column on the first row)
        logic ext_ok;    // next row covers the whole run
        logic out_free;  // output register can take a result
    } t_sts;

endpackage

@@ hdl/sgrm_ctrl.sv @@
`timescale 1ns / 1ps
// Controller for the rectangle merger: one-hot state machine sequencing scan,
// run, downward extension and result. Depends on sgrm_pkg.
module sgrm_ctrl import sgrm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_fetch,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_RUN  = 5'b00100,
        ST_EXT  = 5'b01000,
        ST_RES  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Input is taken only between fetches
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Commands to the datapath
    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = accept && (i_fetch == CMD_LOAD);
        o_cmd.start = accept && (i_fetch == CMD_FETCH);
        o_cmd.scan  = (r_state == ST_SCAN);
        o_cmd.run   = (r_state == ST_RUN);
        o_cmd.ext   = (r_state == ST_EXT);
        o_cmd.res   = (r_state == ST_RES);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.start) begin
                    n_state = i_sts.degen ? ST_RES : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.row_ge_h) begin
                    n_state = ST_RES;
                end else if (i_sts.row_hit) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_state = ST_EXT;
            end
            ST_EXT: begin
                if (!i_sts.ext_ok) begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/sgrm_dp.sv @@
`timescale 1ns / 1ps
// Datapath for the rectangle merger: free-cell row memory with per-row valid
// bits, scan position, run finder, tile scaling and output register. Depends on sgrm_pkg.
module sgrm_dp import sgrm_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in_data,
    output t_sts      o_sts,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int SW    = MAX_COLS + 1;
    localparam int HMAX  = (MAX_ROWS < 127) ? MAX_ROWS : 127;
    localparam int RW    = $clog2(HMAX + 2);
    localparam int DEPTH = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (RW > ROW_IDX_W) ? RW : ROW_IDX_W;

    // Effective map size
    logic [CW-1:0]       eff_w;
    logic [RW-1:0]       eff_h;
    logic [MAX_COLS-1:0] wm;
    logic                degen;

    // Scan position and working registers
    logic [RW-1:0]       r_scan_row;
    logic [CW-1:0]       r_scan_col;
    logic [RW-1:0]       r_row;
    logic [RW-1:0]       r_bot;
    logic                r_first;
    logic                r_done;
    logic [MAX_COLS-1:0] r_x;
    logic [MAX_COLS-1:0] r_cur;
    logic [MAX_COLS-1:0] r_run;
    logic [CW-1:0]       r_c;
    logic [CW-1:0]       r_end1;

    // Row memory (free cells: solid and not covered)
    logic [MAX_COLS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]    r_vld;
    logic [MAX_COLS-1:0] r_rd_data;
    logic                r_rd_ok;
    logic [RW-1:0]       rd_row;
    logic [AW-1:0]       rd_addr;
    logic                rd_in_range;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [MAX_COLS-1:0] mem_wdata;
    logic                load_ok;

    // Run finding
    logic [MAX_COLS-1:0] row_eff;
    logic [CW-1:0]       c0;
    logic [MAX_COLS-1:0] himask;
    logic [MAX_COLS-1:0] x;
    logic [CW-1:0]       c_new;
    logic [SW-1:0]       s;
    logic [MAX_COLS-1:0] run_new;
    logic [CW-1:0]       end1;
    logic [RW-1:0]       nb;
    logic                ext_ok;

    // Result scaling
    logic [CW-1:0]       len;
    logic [RW-1:0]       hgt;
    logic [CW+7:0]       prod_x;
    logic [RW+7:0]       prod_y;
    logic [CW+7:0]       prod_w;
    logic [RW+7:0]       prod_h;
    logic                out_free;
    logic                r_out_valid;
    t_out_item           r_out_data;

    // Effective sizes and width mask
    always_comb begin
        eff_w = (i_cfg.map_width > MAP_DIM_W'(MAX_COLS)) ? CW'(MAX_COLS)
                                                          : CW'(i_cfg.map_width);
        eff_h = (i_cfg.map_height > MAP_DIM_W'(HMAX)) ? RW'(HMAX)
                                                       : RW'(i_cfg.map_height);
        for (int i = 0; i < MAX_COLS; i++) begin
            wm[i] = (CW'(i) < eff_w);
        end
    end

    assign degen = (eff_w == '0) || (eff_h == '0) ||
                   (i_cfg.tile_width == '0) || (i_cfg.tile_height == '0);

    // Read address: next row needed by the following cycle
    always_comb begin
        if (i_cmd.scan) begin
            rd_row = r_row + 1'b1;
        end else if (i_cmd.run) begin
            rd_row = r_bot + 1'b1;
        end else if (i_cmd.ext) begin
            rd_row = r_bot + RW'(2);
        end else begin
            rd_row = r_scan_row;
        end
    end

    assign rd_addr     = rd_row[AW-1:0];
    assign rd_in_range = (rd_row < RW'(DEPTH));
    assign row_eff     = r_rd_ok ? r_rd_data : '0;

    // Scan: first free cell at or after the scan column (from column 0 after the first row)
    always_comb begin
        c0 = r_first ? r_scan_col : '0;
        for (int i = 0; i < MAX_COLS; i++) begin
            himask[i] = (CW'(i) >= c0);
        end
        x     = row_eff & wm & himask;
        c_new = '0;
        for (int i = MAX_COLS - 1; i >= 0; i--) begin
            if (x[i]) begin
                c_new = CW'(i);
            end
        end
    end

    // Run: adding the lowest set bit carries through the run to its end
    always_comb begin
        s       = {1'b0, r_x} + (SW'(1) << r_c);
        run_new = r_x & ~s[MAX_COLS-1:0];
        end1    = '0;
        for (int i = SW - 1; i >= 0; i--) begin
            if (s[i]) begin
                end1 = CW'(i);
            end
        end
    end

    // Extension check on the row below the current bottom
    assign nb     = r_bot + 1'b1;
    assign ext_ok = (nb < eff_h) && ((row_eff & r_run) == r_run);

    // Memory write port: loads and coverage updates
    assign load_ok = i_cmd.load && (IW'(i_in_data.row_index) < IW'(eff_h));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_bot[AW-1:0];
        mem_wdata = r_cur & ~run_new;
        if (load_ok) begin
            mem_we    = 1'b1;
            mem_waddr = i_in_data.row_index[AW-1:0];
            mem_wdata = i_in_data.row_mask[MAX_COLS-1:0];
        end else if (i_cmd.run) begin
            mem_we    = 1'b1;
        end else if (i_cmd.ext && ext_ok) begin
            mem_we    = 1'b1;
            mem_waddr = nb[AW-1:0];
            mem_wdata = r_rd_data & ~r_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Row valid bits: a row never loaded reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (load_ok) begin
                r_vld[i_in_data.row_index[AW-1:0]] <= 1'b1;
            end
            r_rd_ok <= rd_in_range && r_vld[rd_addr];
        end
    end

    // Scan position and sequencing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row <= '0;
            r_scan_col <= '0;
            r_row      <= '0;
            r_bot      <= '0;
            r_first    <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            if (i_cfg.scan_restart || load_ok) begin
                r_scan_row <= '0;
                r_scan_col <= '0;
            end
            if (i_cmd.start) begin
                r_row   <= r_scan_row;
                r_first <= 1'b1;
                r_done  <= degen;
            end
            if (i_cmd.scan) begin
                if (r_row >= eff_h) begin
                    r_done     <= 1'b1;
                    r_scan_row <= eff_h;
                    r_scan_col <= '0;
                end else if (x != '0) begin
                    r_bot <= r_row;
                end else begin
                    r_row   <= r_row + 1'b1;
                    r_first <= 1'b0;
                end
            end
            if (i_cmd.run) begin
                if (end1 >= eff_w) begin
                    r_scan_row <= r_row + 1'b1;
                    r_scan_col <= '0;
                end else begin
                    r_scan_row <= r_row;
                    r_scan_col <= end1;
                end
            end
            if (i_cmd.ext && ext_ok) begin
                r_bot <= nb;
            end
        end
    end

    // Run payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_x   <= x;
            r_cur <= row_eff;
            r_c   <= c_new;
        end
        if (i_cmd.run) begin
            r_run  <= run_new;
            r_end1 <= end1;
        end
    end

    // Tile scaling, registered in the output stage
    assign len    = r_end1 - r_c;
    assign hgt    = r_bot - r_row + 1'b1;
    assign prod_x = r_c * i_cfg.tile_width;
    assign prod_y = r_row * i_cfg.tile_height;
    assign prod_w = len * i_cfg.tile_width;
    assign prod_h = hgt * i_cfg.tile_height;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res && out_free) begin
            if (r_done) begin
                r_out_data          <= '0;
                r_out_data.done_res <= 1'b1;
            end else begin
                r_out_data.done_res <= 1'b0;
                r_out_data.rect_x   <= RECT_W'(prod_x);
                r_out_data.rect_y   <= RECT_W'(prod_y);
                r_out_data.rect_w   <= RECT_W'(prod_w);
                r_out_data.rect_h   <= RECT_W'(prod_h);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Status to the controller
    always_comb begin
        o_sts          = '0;
        o_sts.degen    = degen;
        o_sts.row_ge_h = (r_row >= eff_h);
        o_sts.row_hit  = (x != '0);
        o_sts.ext_ok   = ext_ok;
        o_sts.out_free = out_free;
    end

    // A run is only formed from a row that had a free cell
    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.run |-> (r_x != '0))
        else $error("run formed from an empty row");

    // The rectangle starts at the scanned row
    a_run_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.run |-> (r_bot == r_row))
        else $error("bottom row not aligned with top row at run");

    // A rectangle result has a positive span in both directions
    a_rect_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res && !r_done) |-> ((r_end1 > r_c) && (r_bot >= r_row)))
        else $error("empty rectangle reported");

endmodule

@@ hdl/solid_grid_rectangle_merger_core.sv @@
`timescale 1ns / 1ps
// Top level of the solid grid rectangle merger: configuration registers and
// the controller/datapath pair. Depends on sgrm_pkg, sgrm_ctrl, sgrm_dp.
//
//  Channel  Signals                              Direction  Payload
//  in       i_in_valid / o_in_ready / i_in_data  input      t_in_item (load or fetch)
//  out      o_out_valid / i_out_ready / o_out_data output   t_out_item (one per fetch)
//  cfg      i_cfg_we / i_cfg_idx / i_cfg_data    input      8-bit register write
//
// A load does not leave the idle state; the next transaction can follow right after it.
// A fetch scans rows at one row per cycle (one memory read each), then forms the run,
// extends it downward at one row per cycle, and moves the result into the output register
// once that register is free; a degenerate configuration goes straight to the result.
// Reset is synchronous, active low: all rows read empty, scan restarts, config to defaults.
// A result waiting in the output register does not block loads; the next fetch
// holds its result until the output register frees.
module solid_grid_rectangle_merger_core import sgrm_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [MAP_DIM_W-1:0] r_map_width;
    logic [MAP_DIM_W-1:0] r_map_height;
    logic [TILE_W-1:0]    r_tile_width;
    logic [TILE_W-1:0]    r_tile_height;
    t_cfg                 cfg;
    t_cmd                 cmd;
    t_sts                 sts;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width   <= '0;
            r_map_height  <= '0;
            r_tile_width  <= TILE_W'(8);
            r_tile_height <= TILE_W'(8);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAP_WIDTH:   r_map_width   <= i_cfg_data[MAP_DIM_W-1:0];
                CFG_MAP_HEIGHT:  r_map_height  <= i_cfg_data[MAP_DIM_W-1:0];
                CFG_TILE_WIDTH:  r_tile_width  <= i_cfg_data[TILE_W-1:0];
                CFG_TILE_HEIGHT: r_tile_height <= i_cfg_data[TILE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Map size writes restart the scan but keep coverage
    always_comb begin
        cfg              = '0;
        cfg.map_width    = r_map_width;
        cfg.map_height   = r_map_height;
        cfg.tile_width   = r_tile_width;
        cfg.tile_height  = r_tile_height;
        cfg.scan_restart = i_cfg_we &&
                           ((i_cfg_idx == CFG_MAP_WIDTH) || (i_cfg_idx == CFG_MAP_HEIGHT));
    end

    sgrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_fetch    (i_in_data.command),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    sgrm_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
